@@ design/rct_pkg.sv @@
// Shared action and status codes for the range conflict table.
`timescale 1ns / 1ps
`default_nettype none

package rct_pkg;

  typedef logic [1:0] action_t;
  typedef logic [2:0] status_t;

  localparam action_t ACT_INSERT = 2'd0;
  localparam action_t ACT_LOCATE = 2'd1;
  localparam action_t ACT_CLEAR  = 2'd2;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_CONFLICT  = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_FOUND     = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;
  localparam status_t ST_CLEARED   = 3'd5;

  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;

endpackage

`default_nettype wire

@@ design/rct_match.sv @@
// Parallel overlap compare over all entries and lowest-range selection.
`timescale 1ns / 1ps
`default_nettype none

module rct_match #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 48
) (
  input  wire logic [ENTRIES-1:0]   valid,
  input  wire logic [ADDR_BITS-1:0] entry_low  [ENTRIES],
  input  wire logic [ADDR_BITS-1:0] entry_high [ENTRIES],
  input  wire logic [ENTRIES-1:0]   prec       [ENTRIES],
  input  wire logic [ADDR_BITS-1:0] lo,
  input  wire logic [ADDR_BITS-1:0] hi,
  output logic      [ENTRIES-1:0]   below,
  output logic                      hit,
  output logic      [ADDR_BITS-1:0] match_lo,
  output logic      [ADDR_BITS-1:0] match_hi
);

  logic [ENTRIES-1:0] ov;
  logic [ENTRIES-1:0] winner;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ov[i]    = valid[i] && (lo <= entry_high[i]) && (hi >= entry_low[i]);
      below[i] = entry_low[i] < lo;
    end
  end

  // prec[i] marks the entries whose low end lies below that of entry i;
  // stored ranges are disjoint, so exactly one overlapping entry has none.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      winner[i] = ov[i] && !(|(ov & prec[i]));
    end
  end

  always_comb begin
    match_lo = '0;
    match_hi = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_lo = match_lo | (entry_low[i]  & {ADDR_BITS{winner[i]}});
      match_hi = match_hi | (entry_high[i] & {ADDR_BITS{winner[i]}});
    end
  end

  assign hit = |ov;

endmodule

`default_nettype wire

@@ design/range_conflict_table_unit.sv @@
// Top level: table of disjoint address ranges with insert, locate and clear.
// Each input word passes the input register, then the result register; a stall
//   on the result port (m_axis_tready low) holds it in place.
// Throughput: 1 word per cycle while the result port is not stalled; every entry is compared in parallel.
// Reset clears the valid marks and both pipeline stages at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module range_conflict_table_unit #(
  parameter int ENTRIES   = 64,
  parameter int ADDR_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // action, range_lo, range_hi (lowest bit up), zero padded to bytes
  input  wire logic [((rct_pkg::ACTION_W + 2 * ADDR_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // status, match_lo, match_hi (lowest bit up), zero padded to bytes
  output logic      [((rct_pkg::STATUS_W + 2 * ADDR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int OUT_W = ((rct_pkg::STATUS_W + 2 * ADDR_BITS + 7) / 8) * 8;

  // table state
  logic [ENTRIES-1:0]   valid;
  logic [ADDR_BITS-1:0] entry_low  [ENTRIES];
  logic [ADDR_BITS-1:0] entry_high [ENTRIES];
  logic [ENTRIES-1:0]   prec       [ENTRIES];

  // input stage
  logic                 s1_v;
  rct_pkg::action_t     s1_act;
  logic [ADDR_BITS-1:0] s1_lo;
  logic [ADDR_BITS-1:0] s1_hi;

  // result stage
  logic                 o_v;
  rct_pkg::status_t     o_status;
  logic [ADDR_BITS-1:0] o_lo;
  logic [ADDR_BITS-1:0] o_hi;

  logic                 adv;
  logic                 move;
  logic [ADDR_BITS-1:0] in_lo;
  logic [ADDR_BITS-1:0] in_hi;
  logic                 in_swap;

  logic [ENTRIES-1:0]   below;
  logic                 hit;
  logic [ADDR_BITS-1:0] hit_lo;
  logic [ADDR_BITS-1:0] hit_hi;
  logic [ENTRIES-1:0]   free;
  logic [ENTRIES-1:0]   free_oh;

  rct_pkg::status_t     status_next;
  logic [ADDR_BITS-1:0] o_lo_next;
  logic [ADDR_BITS-1:0] o_hi_next;
  logic                 do_ins;
  logic                 do_clr;

  assign adv           = !o_v || m_axis_tready;
  assign s_axis_tready = !s1_v || adv;
  assign move          = s1_v && adv;

  assign in_lo   = s_axis_tdata[rct_pkg::ACTION_W +: ADDR_BITS];
  assign in_hi   = s_axis_tdata[rct_pkg::ACTION_W + ADDR_BITS +: ADDR_BITS];
  assign in_swap = in_hi < in_lo;

  rct_match #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_match (
    .valid      (valid),
    .entry_low  (entry_low),
    .entry_high (entry_high),
    .prec       (prec),
    .lo         (s1_lo),
    .hi         (s1_hi),
    .below      (below),
    .hit        (hit),
    .match_lo   (hit_lo),
    .match_hi   (hit_hi)
  );

  // lowest free slot as a one-hot vector
  assign free    = ~valid;
  assign free_oh = free & (~free + {{(ENTRIES-1){1'b0}}, 1'b1});

  always_comb begin
    status_next = rct_pkg::ST_NOT_FOUND;
    o_lo_next   = '0;
    o_hi_next   = '0;
    do_ins      = 1'b0;
    do_clr      = 1'b0;
    case (s1_act)
      rct_pkg::ACT_INSERT: begin
        if (hit) begin
          status_next = rct_pkg::ST_CONFLICT;
          o_lo_next   = hit_lo;
          o_hi_next   = hit_hi;
        end else if (|free) begin
          status_next = rct_pkg::ST_INSERTED;
          do_ins      = 1'b1;
        end else begin
          status_next = rct_pkg::ST_FULL;
        end
      end
      rct_pkg::ACT_LOCATE: begin
        if (hit) begin
          status_next = rct_pkg::ST_FOUND;
          o_lo_next   = hit_lo;
          o_hi_next   = hit_hi;
        end
      end
      rct_pkg::ACT_CLEAR: begin
        status_next = rct_pkg::ST_CLEARED;
        do_clr      = 1'b1;
      end
      default: begin
        status_next = rct_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      o_v   <= 1'b0;
      valid <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_v <= s_axis_tvalid;
      end
      if (adv) begin
        o_v <= s1_v;
      end
      if (move && do_clr) begin
        valid <= '0;
      end else if (move && do_ins) begin
        valid <= valid | free_oh;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_act <= s_axis_tdata[rct_pkg::ACTION_W-1:0];
      s1_lo  <= in_swap ? in_hi : in_lo;
      s1_hi  <= in_swap ? in_lo : in_hi;
    end
    if (move) begin
      o_status <= status_next;
      o_lo     <= o_lo_next;
      o_hi     <= o_hi_next;
    end
  end

  // entry store and pairwise order of low ends; new entry gets its row,
  // and its column in every other row
  always_ff @(posedge clk) begin
    if (move && do_ins) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (free_oh[i]) begin
          entry_low[i]  <= s1_lo;
          entry_high[i] <= s1_hi;
          prec[i]       <= below & ~free_oh;
        end else begin
          prec[i] <= (prec[i] & ~free_oh) | (free_oh & {ENTRIES{~below[i]}});
        end
      end
    end
  end

  assign m_axis_tvalid = o_v;
  assign m_axis_tdata  = OUT_W'({o_hi, o_lo, o_status});

endmodule

`default_nettype wire

@@ design/rct_checker.sv @@
// Port-level checks on the range conflict table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rct_checker #(
  parameter int ADDR_BITS = 48
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [((rct_pkg::STATUS_W + 2 * ADDR_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int LO_AT = rct_pkg::STATUS_W;
  localparam int HI_AT = rct_pkg::STATUS_W + ADDR_BITS;

  logic [rct_pkg::STATUS_W-1:0] st;
  logic [ADDR_BITS-1:0]         mlo;
  logic [ADDR_BITS-1:0]         mhi;

  assign st  = m_axis_tdata[rct_pkg::STATUS_W-1:0];
  assign mlo = m_axis_tdata[LO_AT +: ADDR_BITS];
  assign mhi = m_axis_tdata[HI_AT +: ADDR_BITS];

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> st <= rct_pkg::ST_CLEARED)
    else $error("status code out of range");

  // only a conflict or a find carries a stored range
  a_match_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st != rct_pkg::ST_CONFLICT && st != rct_pkg::ST_FOUND
      |-> mlo == '0 && mhi == '0)
    else $error("match fields set without a hit");

  // input only backs up behind a full, stalled pipeline
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input word refused with room in the pipeline");

endmodule

bind range_conflict_table_unit rct_checker #(
  .ADDR_BITS (ADDR_BITS)
) u_rct_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
